// File: design/dbdf_pkg.sv
// ----------------------------------------------------------------------------
// dbdf_pkg: shared types and constants for the box decode filter
// Register indexes, field widths and the per-axis configuration bundle.
// ----------------------------------------------------------------------------
package dbdf_pkg;

   localparam int NUM_ANCHORS = 8400;

   localparam int ANCHOR_W = 14;
   localparam int COORD_W  = 14;
   localparam int CONF_W   = 16;
   localparam int SCALE_W  = 16;
   localparam int FRAME_W  = 13;
   localparam int MINSZ_W  = 12;
   localparam int OUT_W    = 16;

   // Offset, edge and clipped size widths inside the axis pipe
   localparam int DPOS_W = 15;
   localparam int EDGE_W = 22;
   localparam int CLIP_W = 24;

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 96;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CONF_THRESHOLD = 3'd0,
      REG_PAD_X          = 3'd1,
      REG_PAD_Y          = 3'd2,
      REG_INV_SCALE      = 3'd3,
      REG_FRAME_WIDTH    = 3'd4,
      REG_FRAME_HEIGHT   = 3'd5,
      REG_MIN_SIZE       = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic [COORD_W-1:0] pad;
      logic [FRAME_W-1:0] frame;
      logic [SCALE_W-1:0] inv_scale;
   } axis_cfg_type;

endpackage

// File: design/dbdf_axis.sv
// ----------------------------------------------------------------------------
// dbdf_axis: one-axis letterbox decode pipe
// Three register stages: offset, scale multiply, edge and clipped size.
// ----------------------------------------------------------------------------
module dbdf_axis (
   input  logic                          clock,
   input  logic                          en,
   input  dbdf_pkg::axis_cfg_type        cfg,
   input  logic [dbdf_pkg::COORD_W-1:0]  center,
   input  logic [dbdf_pkg::COORD_W-1:0]  size,
   output logic [dbdf_pkg::EDGE_W-1:0]   edge_q4,
   output logic signed [dbdf_pkg::CLIP_W-1:0] clip_q4
);
   import dbdf_pkg::*;

   logic signed [16:0]        d_in;
   logic [DPOS_W-1:0]         dpos_in, dpos_ff;
   logic [COORD_W-1:0]        size_ff;
   logic [DPOS_W+SCALE_W-1:0] eprod_in, eprod_ff;
   logic [COORD_W+SCALE_W-1:0] sprod_in, sprod_ff;
   logic [EDGE_W-1:0]         edge_in, edge_ff;
   logic [EDGE_W-1:0]         scaled;
   logic signed [CLIP_W-1:0]  room, s_ext, clip_in, clip_ff;

   // Offset at 1/32 pixel: 2*c - size - 2*pad, clamp at zero
   always_comb begin
      d_in = $signed({2'b00, center, 1'b0}) - $signed({3'b000, size})
             - $signed({2'b00, cfg.pad, 1'b0});
      dpos_in = d_in[16] ? '0 : d_in[DPOS_W-1:0];
   end

   assign eprod_in = dpos_ff * cfg.inv_scale;
   assign sprod_in = size_ff * cfg.inv_scale;

   always_comb begin
      edge_in = eprod_ff[DPOS_W+SCALE_W-1:9];
      scaled  = sprod_ff[COORD_W+SCALE_W-1:8];
      room    = $signed({7'b0, cfg.frame, 4'b0000}) - $signed({2'b00, edge_in});
      s_ext   = $signed({2'b00, scaled});
      clip_in = (s_ext < room) ? s_ext : room;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dpos_ff  <= dpos_in;
         size_ff  <= size;
         eprod_ff <= eprod_in;
         sprod_ff <= sprod_in;
         edge_ff  <= edge_in;
         clip_ff  <= clip_in;
      end
   end

   assign edge_q4 = edge_ff;
   assign clip_q4 = clip_ff;

endmodule

// File: design/detection_box_decode_filter.sv
// ----------------------------------------------------------------------------
// detection_box_decode_filter: letterbox box decode and filter
// Maps detector anchors back to frame coordinates and drops weak or tiny boxes.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one anchor per transaction; rsp_* returns one decoded box per
//   kept anchor, in input order. Anchors with a low confidence, an index at or
//   above the anchor count, or a clipped width or height under min_size give
//   no response transaction.
//   csr_* writes one register per transaction (index, data); csr_ready is
//   always high. Write registers only while no anchor is in flight.
//   The 4-stage pipeline (offset, scale multiply, edge/clip, filter and
//   saturate) advances as a whole and takes one anchor per cycle unless a
//   finished response is held at the output.
//   When the receiver stalls a held response, the whole pipeline holds and
//   req_tready drops; nothing is lost or repeated.
//   Reset clears all stage valid bits and loads the register defaults
//   (threshold 0.5, no pad, unit scale, 640x640 frame, min size 20).
// ----------------------------------------------------------------------------
module detection_box_decode_filter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // anchor[13:0] center_x[27:14] center_y[41:28] width[55:42] height[69:56]
   // conf[85:70], zero fill above
   input  logic [dbdf_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // anchor[13:0] conf[29:14] x[45:30] y[61:46] width[77:62] height[93:78],
   // zero fill above
   output logic [dbdf_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dbdf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dbdf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dbdf_pkg::*;

   logic [CONF_W-1:0]  conf_threshold_ff;
   logic [COORD_W-1:0] pad_x_ff, pad_y_ff;
   logic [SCALE_W-1:0] inv_scale_ff;
   logic [FRAME_W-1:0] frame_width_ff, frame_height_ff;
   logic [MINSZ_W-1:0] min_size_ff;

   logic               en;
   logic [ANCHOR_W-1:0] anchor_in;
   logic [COORD_W-1:0] cx_in, cy_in, w_in, h_in;
   logic [CONF_W-1:0]  conf_in;
   logic               s1_valid_in, s4_valid_in;
   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic [ANCHOR_W-1:0] anchor1_ff, anchor2_ff, anchor3_ff, anchor4_ff;
   logic [CONF_W-1:0]  conf1_ff, conf2_ff, conf3_ff, conf4_ff;

   axis_cfg_type       cfg_x, cfg_y;
   logic [EDGE_W-1:0]  edge_x, edge_y;
   logic signed [CLIP_W-1:0] clip_x, clip_y, lim;

   logic [OUT_W-1:0]   x_in, y_in, bw_in, bh_in;
   logic [OUT_W-1:0]   x_ff, y_ff, bw_ff, bh_ff;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         conf_threshold_ff <= 16'd32768;
         pad_x_ff          <= '0;
         pad_y_ff          <= '0;
         inv_scale_ff      <= 16'd256;
         frame_width_ff    <= 13'd640;
         frame_height_ff   <= 13'd640;
         min_size_ff       <= 12'd20;
      end else if (csr_valid) begin
         case (csr_reg_type'(csr_index))
            REG_CONF_THRESHOLD: conf_threshold_ff <= csr_wdata;
            REG_PAD_X:          pad_x_ff          <= csr_wdata[COORD_W-1:0];
            REG_PAD_Y:          pad_y_ff          <= csr_wdata[COORD_W-1:0];
            REG_INV_SCALE:      inv_scale_ff      <= csr_wdata;
            REG_FRAME_WIDTH:    frame_width_ff    <= csr_wdata[FRAME_W-1:0];
            REG_FRAME_HEIGHT:   frame_height_ff   <= csr_wdata[FRAME_W-1:0];
            REG_MIN_SIZE:       min_size_ff       <= csr_wdata[MINSZ_W-1:0];
            default: ;
         endcase
      end
   end

   // Whole pipe advances unless a finished box is held at the output
   assign en         = !s4_valid_ff || rsp_tready;
   assign req_tready = en;

   assign anchor_in = req_tdata[13:0];
   assign cx_in     = req_tdata[27:14];
   assign cy_in     = req_tdata[41:28];
   assign w_in      = req_tdata[55:42];
   assign h_in      = req_tdata[69:56];
   assign conf_in   = req_tdata[85:70];

   // Drop out-of-range anchors and weak detections at entry
   assign s1_valid_in = req_tvalid
                        && ({1'b0, anchor_in} < 15'(NUM_ANCHORS))
                        && (conf_in >= conf_threshold_ff);

   assign cfg_x = '{pad: pad_x_ff, frame: frame_width_ff, inv_scale: inv_scale_ff};
   assign cfg_y = '{pad: pad_y_ff, frame: frame_height_ff, inv_scale: inv_scale_ff};

   dbdf_axis u_axis_x (
      .clock   (clock),
      .en      (en),
      .cfg     (cfg_x),
      .center  (cx_in),
      .size    (w_in),
      .edge_q4 (edge_x),
      .clip_q4 (clip_x)
   );

   dbdf_axis u_axis_y (
      .clock   (clock),
      .en      (en),
      .cfg     (cfg_y),
      .center  (cy_in),
      .size    (h_in),
      .edge_q4 (edge_y),
      .clip_q4 (clip_y)
   );

   // Minimum size filter and output saturation
   always_comb begin
      lim         = $signed({8'b0, min_size_ff, 4'b0000});
      s4_valid_in = s3_valid_ff && (clip_x >= lim) && (clip_y >= lim);
      x_in  = (|edge_x[EDGE_W-1:OUT_W]) ? '1 : edge_x[OUT_W-1:0];
      y_in  = (|edge_y[EDGE_W-1:OUT_W]) ? '1 : edge_y[OUT_W-1:0];
      bw_in = clip_x[CLIP_W-1] ? '0 :
              ((|clip_x[CLIP_W-2:OUT_W]) ? '1 : clip_x[OUT_W-1:0]);
      bh_in = clip_y[CLIP_W-1] ? '0 :
              ((|clip_y[CLIP_W-2:OUT_W]) ? '1 : clip_y[OUT_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         anchor1_ff <= anchor_in;
         anchor2_ff <= anchor1_ff;
         anchor3_ff <= anchor2_ff;
         anchor4_ff <= anchor3_ff;
         conf1_ff   <= conf_in;
         conf2_ff   <= conf1_ff;
         conf3_ff   <= conf2_ff;
         conf4_ff   <= conf3_ff;
         x_ff       <= x_in;
         y_ff       <= y_in;
         bw_ff      <= bw_in;
         bh_ff      <= bh_in;
      end
   end

   assign rsp_tvalid = s4_valid_ff;
   assign rsp_tdata  = {2'b00, bh_ff, bw_ff, y_ff, x_ff, conf4_ff, anchor4_ff};

   // A kept anchor reaches the multiply stage on the next advance
   a_stage_advance: assert property (@(posedge clock) disable iff (reset)
      (en && s1_valid_ff) |=> s2_valid_ff)
      else $error("kept anchor lost between entry and multiply stage");

   // A stalled pipe holds the offset, multiply and edge/clip stage valid bits
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> ($stable(s1_valid_ff) && $stable(s2_valid_ff) && $stable(s3_valid_ff)))
      else $error("in-flight item changed during stall");

   // Only anchors that passed the entry filter enter the offset stage
   a_entry_filter: assert property (@(posedge clock) disable iff (reset)
      (en && !s1_valid_in) |=> !s1_valid_ff)
      else $error("dropped anchor entered the pipeline");

   // Reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for detection_box_decode_filter
// Streams detector anchors through the block under several register settings,
// predicts each kept box in a scoreboard and compares every response
// transaction field by field, in order. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dbdf_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 3'd7;
   localparam int DRAIN_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_ITEMS   = 112;
   localparam int RANDOM_PHASES = 8;

   typedef struct packed {
      logic [CONF_W-1:0]   conf;
      logic [COORD_W-1:0]  box_h;
      logic [COORD_W-1:0]  box_w;
      logic [COORD_W-1:0]  center_y;
      logic [COORD_W-1:0]  center_x;
      logic [ANCHOR_W-1:0] anchor;
   } anchor_item_type;

   typedef struct packed {
      logic [OUT_W-1:0]    box_h;
      logic [OUT_W-1:0]    box_w;
      logic [OUT_W-1:0]    top;
      logic [OUT_W-1:0]    left;
      logic [CONF_W-1:0]   conf;
      logic [ANCHOR_W-1:0] anchor;
   } decoded_box_type;

   class box_scoreboard_type;
      longint thr, pad_x, pad_y, inv_scale, frame_w, frame_h, min_size;
      decoded_box_type expected_boxes[$];
      int mismatches;

      function new();
         thr       = 32768;
         pad_x     = 0;
         pad_y     = 0;
         inv_scale = 256;
         frame_w   = 640;
         frame_h   = 640;
         min_size  = 20;
         mismatches = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            REG_CONF_THRESHOLD: thr = data;
            REG_PAD_X:          pad_x = data[COORD_W-1:0];
            REG_PAD_Y:          pad_y = data[COORD_W-1:0];
            REG_INV_SCALE:      inv_scale = data;
            REG_FRAME_WIDTH:    frame_w = data[FRAME_W-1:0];
            REG_FRAME_HEIGHT:   frame_h = data[FRAME_W-1:0];
            REG_MIN_SIZE:       min_size = data[MINSZ_W-1:0];
            default: ;
         endcase
      endfunction

      // Offset at 1/32 pixel, so the halved size stays exact
      function longint edge_offset(longint c, longint size, longint pad);
         longint d;
         d = 2 * c - size - 2 * pad;
         if (d <= 0) return 0;
         return (d * inv_scale) >>> 9;
      endfunction

      // Clip against the unsaturated edge; the result may go negative
      function longint clipped_size(longint size, longint left, longint frame);
         longint s, room;
         s = (size * inv_scale) >>> 8;
         room = frame * 16 - left;
         return (s < room) ? s : room;
      endfunction

      function logic [OUT_W-1:0] sat16(longint v);
         if (v < 0) return '0;
         if (v > 65535) return '1;
         return v[OUT_W-1:0];
      endfunction

      function bit decode_anchor(anchor_item_type a, output decoded_box_type b);
         longint left, top, bw, bh, lim;
         b = '0;
         if (a.anchor >= NUM_ANCHORS) return 0;
         if (a.conf < thr) return 0;
         left = edge_offset(a.center_x, a.box_w, pad_x);
         top  = edge_offset(a.center_y, a.box_h, pad_y);
         bw   = clipped_size(a.box_w, left, frame_w);
         bh   = clipped_size(a.box_h, top, frame_h);
         lim  = min_size * 16;
         if (bw < lim || bh < lim) return 0;
         b.anchor = a.anchor;
         b.conf   = a.conf;
         b.left   = sat16(left);
         b.top    = sat16(top);
         b.box_w  = sat16(bw);
         b.box_h  = sat16(bh);
         return 1;
      endfunction

      function void note_anchor(anchor_item_type a);
         decoded_box_type b;
         if (decode_anchor(a, b)) expected_boxes.insert(expected_boxes.size(), b);
      endfunction

      function void compare_field(string field, longint want, longint got);
         if (want != got) begin
            $display("%0t ERROR: %s expected %0d actual %0d", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_box(decoded_box_type got);
         decoded_box_type want;
         if (expected_boxes.size() == 0) begin
            $display("%0t ERROR: unexpected box, expected none actual anchor %0d",
                     $time, got.anchor);
            mismatches++;
            return;
         end
         want = expected_boxes.pop_front();
         compare_field("anchor", want.anchor, got.anchor);
         compare_field("conf", want.conf, got.conf);
         compare_field("left", want.left, got.left);
         compare_field("top", want.top, got.top);
         compare_field("width", want.box_w, got.box_w);
         compare_field("height", want.box_h, got.box_h);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    cycle_count = 0;

   box_scoreboard_type box_sb;

   detection_box_decode_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t ERROR: timeout after %0d cycles", $time, CYCLE_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Observe every transaction at the edge where it happens
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) box_sb.set_reg(csr_index, csr_wdata);
         if (req_tvalid && req_tready)
            box_sb.note_anchor(req_tdata[$bits(anchor_item_type)-1:0]);
         if (rsp_tvalid && rsp_tready)
            box_sb.check_box(rsp_tdata[$bits(decoded_box_type)-1:0]);
      end
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receiver: short stalls mostly, a few long ones, and long ready stretches
   initial begin
      int stall;
      @(posedge clock);
      forever begin
         stall = gap_length();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(40, 200)) @(posedge clock);
         else repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   function automatic anchor_item_type make_item(int anchor, int cx, int cy, int w, int h,
                                                 int conf);
      anchor_item_type a;
      a.anchor   = ANCHOR_W'(anchor);
      a.center_x = COORD_W'(cx);
      a.center_y = COORD_W'(cy);
      a.box_w    = COORD_W'(w);
      a.box_h    = COORD_W'(h);
      a.conf     = CONF_W'(conf);
      return a;
   endfunction

   task automatic send_anchor(anchor_item_type a, int gap);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - $bits(anchor_item_type)){1'b0}}, a};
      do @(posedge clock); while (!req_tready);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Leaves csr_valid high so back-to-back writes need no extra edge
   task automatic write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Hold off until every expected box has come and the pipe has flushed
   task automatic settle();
      if (req_tvalid) req_tvalid <= 1'b0;
      if (csr_valid) csr_valid <= 1'b0;
      @(posedge clock);
      while (box_sb.expected_boxes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_config(logic [15:0] thr, logic [15:0] px, logic [15:0] py,
                               logic [15:0] inv, logic [15:0] fw, logic [15:0] fh,
                               logic [15:0] ms);
      write_reg(REG_CONF_THRESHOLD, thr);
      write_reg(REG_PAD_X, px);
      write_reg(REG_PAD_Y, py);
      write_reg(REG_INV_SCALE, inv);
      write_reg(REG_FRAME_WIDTH, fw);
      write_reg(REG_FRAME_HEIGHT, fh);
      write_reg(REG_MIN_SIZE, ms);
      settle();
   endtask

   task automatic random_config();
      logic [15:0] thr, px, py, inv, fw, fh, ms;
      int r;
      r = $urandom_range(0, 9);
      thr = (r < 2) ? 16'd0 : (r == 2) ? 16'hFFFF : 16'($urandom_range(0, 49152));
      px  = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 10240));
      py  = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 10240));
      r = $urandom_range(0, 9);
      inv = (r < 7) ? 16'($urandom_range(128, 640)) :
            (r < 9) ? 16'($urandom_range(1, 65535)) : 16'd0;
      fw  = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(320, 1920));
      fh  = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(320, 1920));
      ms  = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
      apply_config(thr, px, py, inv, fw, fh, ms);
   endtask

   // Mostly plausible detections above threshold; the rest is raw noise
   task automatic random_phase(int count);
      anchor_item_type a;
      logic [95:0]  noise;
      bit           burst;
      int           n;
      burst = 1'b0;
      for (n = 0; n < count; n++) begin
         if (n % 32 == 0) burst = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) == 0) begin
            noise = {$urandom, $urandom, $urandom};
            a = noise[$bits(anchor_item_type)-1:0];
         end else begin
            a.anchor   = ($urandom_range(0, 9) == 0) ?
                         ANCHOR_W'($urandom_range(NUM_ANCHORS, 16383)) :
                         ANCHOR_W'($urandom_range(0, NUM_ANCHORS - 1));
            a.conf     = ($urandom_range(0, 6) == 0) ?
                         CONF_W'($urandom_range(0, 65535)) :
                         CONF_W'($urandom_range(65535, box_sb.thr));
            a.center_x = COORD_W'($urandom_range(0, 10240));
            a.center_y = COORD_W'($urandom_range(0, 10240));
            a.box_w    = COORD_W'($urandom_range(0, 6000));
            a.box_h    = COORD_W'($urandom_range(0, 6000));
         end
         send_anchor(a, burst ? 0 : gap_length());
      end
      settle();
   endtask

   task automatic directed_tests();
      // Reset register values: threshold edge, index range, clipping, min size
      send_anchor(make_item(0, 0, 0, 0, 0, 0), gap_length());
      send_anchor(make_item(1, 5120, 5120, 1600, 1600, 32768), gap_length());
      send_anchor(make_item(2, 5120, 5120, 1600, 1600, 32767), gap_length());
      send_anchor(make_item(NUM_ANCHORS - 1, 4000, 3000, 900, 700, 65535), gap_length());
      send_anchor(make_item(NUM_ANCHORS, 4000, 3000, 900, 700, 65535), gap_length());
      send_anchor(make_item(16383, 4000, 3000, 900, 700, 65535), gap_length());
      send_anchor(make_item(NUM_ANCHORS - 1, 16383, 16383, 16383, 16383, 65535), 0);
      send_anchor(make_item(3, 16, 16, 16383, 16383, 40000), 0);
      send_anchor(make_item(4, 16383, 5120, 0, 1600, 40000), 0);
      send_anchor(make_item(5, 5120, 5120, 304, 320, 50000), gap_length());
      send_anchor(make_item(6, 5120, 5120, 320, 320, 50000), gap_length());
      send_anchor(make_item(7, 800, 5120, 1600, 1600, 50000), gap_length());
      settle();

      // Largest scale and frame, upper write bits set, zero threshold and size
      apply_config(16'd0, 16'hFFFF, 16'hC000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hF000);
      send_anchor(make_item(8, 16383, 0, 0, 16383, 0), gap_length());
      send_anchor(make_item(9, 16383, 16383, 16383, 16383, 65535), gap_length());
      send_anchor(make_item(10, 8000, 3000, 100, 200, 7), gap_length());
      send_anchor(make_item(NUM_ANCHORS - 1, 0, 0, 16383, 16383, 65535), gap_length());
      settle();

      // Zero inverse scale: kept only while the size floor is zero
      write_reg(REG_INV_SCALE, 16'd0);
      settle();
      send_anchor(make_item(11, 5000, 5000, 3000, 3000, 100), gap_length());
      settle();
      write_reg(REG_MIN_SIZE, 16'd20);
      write_reg(REG_UNMAPPED, 16'hFFFF);
      settle();
      send_anchor(make_item(12, 5000, 5000, 3000, 3000, 100), gap_length());
      settle();

      // Zero frame width, full threshold, smallest scale
      apply_config(16'hFFFF, 16'd0, 16'd0, 16'd1, 16'd0, 16'd1, 16'd0);
      send_anchor(make_item(13, 0, 0, 16383, 16383, 65535), gap_length());
      send_anchor(make_item(14, 0, 0, 16383, 16383, 65534), gap_length());
      settle();
   endtask

   initial begin
      int phase;
      box_sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_tests();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) apply_config(16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 16'd0);
         else if (phase == 1)
            apply_config(16'hFFFF, 16'd10240, 16'd10240, 16'hFFFF, 16'd8191, 16'd8191,
                         16'd4095);
         else random_config();
         random_phase(PHASE_ITEMS);
      end

      if (box_sb.mismatches == 0 && box_sb.expected_boxes.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
